// ----- rtl/core/cbz_pkg.sv -----
// ----------------------------------------------------------------------------
// cbz_pkg
// Shared widths and helpers for the cubic Bezier point and tangent evaluator.
// ----------------------------------------------------------------------------
package cbz_pkg;

  localparam int COORD_BITS  = 16;
  localparam int T_FRAC_BITS = 16;

  localparam int CP_W   = 48;
  localparam int IDX_W  = 2;
  localparam int NUM_CP = 4;
  localparam int NUM_AX = 3;

  localparam int CW = COORD_BITS;
  localparam int DW = COORD_BITS + 1;
  localparam int TW = T_FRAC_BITS + 1;
  localparam int PW = DW + TW + 1;

  localparam int IN_DATA_W  = ((TW + 7) / 8) * 8;
  localparam int OUT_RAW_W  = NUM_AX * CW + NUM_AX * DW;
  localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;

  localparam int PAD_W = NUM_AX * CW + CP_W;

  localparam logic [TW-1:0] T_ONE = TW'(1) << T_FRAC_BITS;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [DW-1:0] diff_t;
  typedef logic signed [PW-1:0] prod_t;
  typedef logic [TW-1:0]        tparam_t;

  typedef enum logic [IDX_W-1:0] {
    REG_CP0 = 2'd0,
    REG_CP1 = 2'd1,
    REG_CP2 = 2'd2,
    REG_CP3 = 2'd3
  } reg_idx_t;

  function automatic coord_t coord_of(input logic [CP_W-1:0] cp, input int axis);
    logic [PAD_W-1:0] padded;
    padded = PAD_W'(cp);
    return coord_t'(padded[axis*CW +: CW]);
  endfunction

  function automatic prod_t scale(input diff_t d, input tparam_t t);
    prod_t a;
    prod_t b;
    a = PW'(d);
    b = PW'($signed({1'b0, t}));
    return a * b;
  endfunction

  function automatic coord_t step(input coord_t base, input prod_t p);
    prod_t sh;
    diff_t s;
    sh = p >>> T_FRAC_BITS;
    s  = DW'(base) + diff_t'(sh[DW-1:0]);
    return coord_t'(s[CW-1:0]);
  endfunction

endpackage

// ----- rtl/core/cubic_bezier_point_tangent_top.sv -----
// ----------------------------------------------------------------------------
// cubic_bezier_point_tangent_top
// Seven-stage pipelined 3D cubic Bezier evaluator: curve point and tangent.
// ----------------------------------------------------------------------------
// One item enters per cycle while the pipeline is not held; the pipeline
// registers t on entry, then runs three de Casteljau levels, each as a
// multiply stage followed by a floor-shift-and-add stage, and the last add
// stage drives the outputs. The whole pipeline holds while out_tready is low
// with a result waiting. Control points are to be written through the cfg
// port by the user while the pipeline is empty; the block does not enforce it.
module cubic_bezier_point_tangent_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [cbz_pkg::IDX_W-1:0]          cfg_index,
  input  logic [cbz_pkg::CP_W-1:0]           cfg_data,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [cbz_pkg::IN_DATA_W-1:0]      in_tdata,   // t_param
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // point_x, point_y, point_z, tangent_x, tangent_y, tangent_z
  output logic [cbz_pkg::OUT_DATA_W-1:0]     out_tdata
);
  import cbz_pkg::*;

  logic [CP_W-1:0] cp_r [NUM_CP];

  logic    en;
  logic    v0_r, v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  tparam_t t0_r, t1_r, t2_r, t3_r, t4_r;
  tparam_t t0_nxt;

  coord_t cp_c    [NUM_AX][NUM_CP];
  prod_t  prod1_nxt [NUM_AX][3];
  prod_t  prod1_r   [NUM_AX][3];
  coord_t base1_r   [NUM_AX][3];
  coord_t z_nxt     [NUM_AX][3];
  coord_t z_r       [NUM_AX][3];
  prod_t  prod2_nxt [NUM_AX][2];
  prod_t  prod2_r   [NUM_AX][2];
  coord_t base2_r   [NUM_AX][2];
  coord_t w_nxt     [NUM_AX][2];
  coord_t w_r       [NUM_AX][2];
  prod_t  prod3_nxt [NUM_AX];
  prod_t  prod3_r   [NUM_AX];
  coord_t base3_r   [NUM_AX];
  diff_t  dif_nxt   [NUM_AX];
  diff_t  dif_r     [NUM_AX];
  coord_t q_nxt     [NUM_AX];
  coord_t q_r       [NUM_AX];
  diff_t  d_r       [NUM_AX];

  assign cfg_ready  = 1'b1;
  assign en         = !v6_r || out_tready;
  assign in_tready  = en;
  assign out_tvalid = v6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_CP; k++) cp_r[k] <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_CP0: cp_r[0] <= cfg_data;
        REG_CP1: cp_r[1] <= cfg_data;
        REG_CP2: cp_r[2] <= cfg_data;
        REG_CP3: cp_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    t0_nxt = (in_tdata[TW-1:0] > T_ONE) ? T_ONE : in_tdata[TW-1:0];
    for (int a = 0; a < NUM_AX; a++) begin
      for (int k = 0; k < NUM_CP; k++) cp_c[a][k] = coord_of(cp_r[k], a);
      for (int k = 0; k < 3; k++)
        prod1_nxt[a][k] = scale(DW'(cp_c[a][k+1]) - DW'(cp_c[a][k]), t0_r);
      for (int k = 0; k < 3; k++) z_nxt[a][k] = step(base1_r[a][k], prod1_r[a][k]);
      for (int k = 0; k < 2; k++)
        prod2_nxt[a][k] = scale(DW'(z_r[a][k+1]) - DW'(z_r[a][k]), t2_r);
      for (int k = 0; k < 2; k++) w_nxt[a][k] = step(base2_r[a][k], prod2_r[a][k]);
      dif_nxt[a]   = DW'(w_r[a][1]) - DW'(w_r[a][0]);
      prod3_nxt[a] = scale(dif_nxt[a], t4_r);
      q_nxt[a]     = step(base3_r[a], prod3_r[a]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_tvalid;
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t0_r <= t0_nxt;
      t1_r <= t0_r;
      t2_r <= t1_r;
      t3_r <= t2_r;
      t4_r <= t3_r;
      for (int a = 0; a < NUM_AX; a++) begin
        for (int k = 0; k < 3; k++) begin
          prod1_r[a][k] <= prod1_nxt[a][k];
          base1_r[a][k] <= cp_c[a][k];
          z_r[a][k]     <= z_nxt[a][k];
        end
        for (int k = 0; k < 2; k++) begin
          prod2_r[a][k] <= prod2_nxt[a][k];
          base2_r[a][k] <= z_r[a][k];
          w_r[a][k]     <= w_nxt[a][k];
        end
        prod3_r[a] <= prod3_nxt[a];
        base3_r[a] <= w_r[a][0];
        dif_r[a]   <= dif_nxt[a];
        q_r[a]     <= q_nxt[a];
        d_r[a]     <= dif_r[a];
      end
    end
  end

  assign out_tdata = OUT_DATA_W'({d_r[2], d_r[1], d_r[0], q_r[2], q_r[1], q_r[0]});

endmodule

// ----- rtl/core/cbz_checker.sv -----
// ----------------------------------------------------------------------------
// cbz_checker
// Port-level checks for the cubic Bezier evaluator, bound to the top level.
// ----------------------------------------------------------------------------
module cbz_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           cfg_ready,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [cbz_pkg::OUT_DATA_W-1:0] out_tdata
);
  import cbz_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  a_stall_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input taken while output stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result present after reset");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready)
    else $error("cfg port not ready");

endmodule

bind cubic_bezier_point_tangent_top cbz_checker u_cbz_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .cfg_ready  (cfg_ready),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
